>>> hdl/srrw_pkg.sv
// Shared types and constants for the selective-repeat receiver window.
`timescale 1ns / 1ps

package srrw_pkg;

    // Receive bitmap depth and derived widths
    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int RUN_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TYPE_W   = 8;
    localparam int SEQ_W    = 32;
    localparam int WIN_W    = 7;
    localparam int CHUNK_W  = 11;
    localparam int WOFF_W   = 43;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 11;

    localparam int CHUNK_MAX = 1472;

    // Header queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Configuration register indexes
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_CHUNK_SIZE  = 1'b1;

    // Packet type codes
    localparam logic [TYPE_W-1:0] PKT_START = 8'd0;
    localparam logic [TYPE_W-1:0] PKT_END   = 8'd1;
    localparam logic [TYPE_W-1:0] PKT_DATA  = 8'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CRC    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_START_ERR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_END_ERR    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SESSION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd5;

    typedef enum logic [2:0] {
        CLS_START,
        CLS_END,
        CLS_DATA,
        CLS_UNKNOWN,
        CLS_BAD_CRC
    } pkt_class_t;

    typedef struct packed {
        pkt_class_t         cls;
        logic [SEQ_W-1:0]   seq;
    } hdr_entry_t;

    typedef struct packed {
        logic [WIN_W-1:0]   win;
        logic [CHUNK_W-1:0] chunk;
    } cfg_t;

    typedef struct packed {
        logic                ack_send;
        logic [SEQ_W-1:0]    ack_seq;
        logic                write_chunk;
        logic [WOFF_W-1:0]   write_offset;
        logic                session_done;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

>>> hdl/srrw_front.sv
// Front part: accepts packet headers, classifies them and queues them.
`timescale 1ns / 1ps

module srrw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [srrw_pkg::TYPE_W-1:0] pkt_type,
    input  logic [srrw_pkg::SEQ_W-1:0]  seq_num,
    input  logic                        checksum_ok,
    output logic                        q_valid,
    input  logic                        q_ready,
    output srrw_pkg::hdr_entry_t        q_entry
);

    srrw_pkg::hdr_entry_t               mem_reg [srrw_pkg::QUEUE_DEPTH];
    logic [srrw_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [srrw_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [srrw_pkg::QCNT_W-1:0]        count_reg, count_next;
    srrw_pkg::hdr_entry_t               new_entry;
    logic                               push;
    logic                               pop;

    always_comb
    begin
        new_entry.seq = seq_num;
        if (!checksum_ok)
        begin
            new_entry.cls = srrw_pkg::CLS_BAD_CRC;
        end
        else
        begin
            case (pkt_type)
                srrw_pkg::PKT_START: new_entry.cls = srrw_pkg::CLS_START;
                srrw_pkg::PKT_END:   new_entry.cls = srrw_pkg::CLS_END;
                srrw_pkg::PKT_DATA:  new_entry.cls = srrw_pkg::CLS_DATA;
                default:             new_entry.cls = srrw_pkg::CLS_UNKNOWN;
            endcase
        end
    end

    assign in_ready = (count_reg != srrw_pkg::QCNT_W'(srrw_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

>>> hdl/srrw_back.sv
// Back part: session state, receive bitmap, window slide and result register.
`timescale 1ns / 1ps

module srrw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srrw_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  srrw_pkg::hdr_entry_t   q_entry,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srrw_pkg::result_t      result
);

    typedef enum logic [1:0] {
        BACK_EXEC  = 2'b01,
        BACK_SLIDE = 2'b10
    } back_state_t;

    back_state_t                          state_reg, state_next;
    logic                                 open_reg, open_next;
    logic [srrw_pkg::SEQ_W-1:0]           sess_reg, sess_next;
    logic [srrw_pkg::SEQ_W-1:0]           base_reg, base_next;
    logic [srrw_pkg::WINDOW_DEPTH-1:0]    map_reg, map_next;
    logic                                 out_valid_reg, out_valid_next;
    srrw_pkg::result_t                    res_reg, res_next;

    logic [srrw_pkg::SEQ_W-1:0]           seq_delta;
    logic [srrw_pkg::IDX_W-1:0]           slot;
    logic                                 in_window;
    logic [srrw_pkg::WOFF_W-1:0]          product;
    logic [srrw_pkg::WINDOW_DEPTH-1:0]    win_mask;
    logic [srrw_pkg::WINDOW_DEPTH-1:0]    run_vec;
    logic [srrw_pkg::RUN_W-1:0]           run;
    logic                                 ack;
    logic                                 wr;
    logic                                 done;
    logic [srrw_pkg::STATUS_W-1:0]        st;

    assign seq_delta = q_entry.seq - base_reg;
    assign in_window = (seq_delta < srrw_pkg::SEQ_W'(cfg.win));
    assign slot      = seq_delta[srrw_pkg::IDX_W-1:0];
    assign product   = srrw_pkg::WOFF_W'(q_entry.seq) * srrw_pkg::WOFF_W'(cfg.chunk);

    // Run of received slots at the base, limited to the window
    always_comb
    begin
        for (int i = 0; i < srrw_pkg::WINDOW_DEPTH; i++)
        begin
            win_mask[i] = (i < int'(cfg.win));
        end
        run_vec = map_reg & win_mask;
        run     = srrw_pkg::RUN_W'(srrw_pkg::WINDOW_DEPTH);
        for (int i = srrw_pkg::WINDOW_DEPTH - 1; i >= 0; i--)
        begin
            if (!run_vec[i])
            begin
                run = srrw_pkg::RUN_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        sess_next      = sess_reg;
        base_next      = base_reg;
        map_next       = map_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        q_ready        = 1'b0;
        ack            = 1'b0;
        wr             = 1'b0;
        done           = 1'b0;
        st             = srrw_pkg::ST_OK;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BACK_EXEC:
            begin
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_ready = 1'b1;
                    case (q_entry.cls)
                        srrw_pkg::CLS_BAD_CRC:
                        begin
                            st = srrw_pkg::ST_BAD_CRC;
                        end
                        srrw_pkg::CLS_START:
                        begin
                            if (open_reg && (q_entry.seq != sess_reg))
                            begin
                                st = srrw_pkg::ST_START_ERR;
                            end
                            else
                            begin
                                open_next = 1'b1;
                                sess_next = q_entry.seq;
                                ack       = 1'b1;
                            end
                        end
                        srrw_pkg::CLS_END:
                        begin
                            if (open_reg && (q_entry.seq != sess_reg))
                            begin
                                st = srrw_pkg::ST_END_ERR;
                            end
                            else
                            begin
                                ack       = 1'b1;
                                done      = 1'b1;
                                open_next = 1'b0;
                                base_next = '0;
                                map_next  = '0;
                            end
                        end
                        srrw_pkg::CLS_DATA:
                        begin
                            if (!open_reg)
                            begin
                                st = srrw_pkg::ST_NO_SESSION;
                            end
                            else if (q_entry.seq < base_reg)
                            begin
                                ack = 1'b1;
                            end
                            else if (!in_window)
                            begin
                                st = srrw_pkg::ST_BEYOND;
                            end
                            else
                            begin
                                ack = 1'b1;
                                if (!map_reg[slot])
                                begin
                                    map_next[slot] = 1'b1;
                                    wr             = 1'b1;
                                end
                                if (seq_delta == '0)
                                begin
                                    state_next = BACK_SLIDE;
                                end
                            end
                        end
                        default:
                        begin
                            st = srrw_pkg::ST_START_ERR;
                        end
                    endcase
                    out_valid_next        = 1'b1;
                    res_next.ack_send     = ack;
                    res_next.ack_seq      = ack ? q_entry.seq : '0;
                    res_next.write_chunk  = wr;
                    res_next.write_offset = wr ? product : '0;
                    res_next.session_done = done;
                    res_next.status       = st;
                end
            end
            BACK_SLIDE:
            begin
                map_next   = map_reg >> run;
                base_next  = base_reg + srrw_pkg::SEQ_W'(run);
                state_next = BACK_EXEC;
            end
            default:
            begin
                state_next = BACK_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_EXEC;
            open_reg      <= 1'b0;
            sess_reg      <= '0;
            base_reg      <= '0;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            sess_reg      <= sess_next;
            base_reg      <= base_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

>>> hdl/selective_repeat_receiver_window.sv
// An accepted header goes into the header queue, then into the back part's result register.
// Throughput: one header per cycle while the output is not stalled; a data packet at the
//   window base then needs the window-slide state (find-first-zero plus shift of the bitmap).
// A two-entry header queue lets input acceptance run ahead of a stalled output.
// Reset (rst_n low, async): no session, base and session number zero, bitmap cleared at
//   once in flip-flops; window_size 64, chunk_size 1456; no clearing pass afterwards.
`timescale 1ns / 1ps

module selective_repeat_receiver_window (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [srrw_pkg::CFG_W-1:0]      cfg_data,
    // header input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [srrw_pkg::TYPE_W-1:0]     pkt_type,
    input  logic [srrw_pkg::SEQ_W-1:0]      seq_num,
    input  logic                            checksum_ok,
    // result output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            ack_send,
    output logic [srrw_pkg::SEQ_W-1:0]      ack_seq,
    output logic                            write_chunk,
    output logic [srrw_pkg::WOFF_W-1:0]     write_offset,
    output logic                            session_done,
    output logic [srrw_pkg::STATUS_W-1:0]   status
);

    logic [srrw_pkg::WIN_W-1:0]     window_size_reg;
    logic [srrw_pkg::CHUNK_W-1:0]   chunk_size_reg;
    srrw_pkg::cfg_t                 cfg_eff;
    logic                           q_valid;
    logic                           q_ready;
    srrw_pkg::hdr_entry_t           q_entry;
    srrw_pkg::result_t              result;

    // Config registers; to be written only while no transaction is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= srrw_pkg::WIN_W'(64);
            chunk_size_reg  <= srrw_pkg::CHUNK_W'(1456);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srrw_pkg::CFG_WINDOW_SIZE: window_size_reg <= cfg_data[srrw_pkg::WIN_W-1:0];
                srrw_pkg::CFG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data[srrw_pkg::CHUNK_W-1:0];
                default:                   window_size_reg <= window_size_reg;
            endcase
        end
    end

    // Clamp: zero acts as one, window capped at the bitmap depth, chunk at the max payload
    always_comb
    begin
        cfg_eff.win = window_size_reg;
        if (window_size_reg == '0)
        begin
            cfg_eff.win = srrw_pkg::WIN_W'(1);
        end
        else if (int'(window_size_reg) > srrw_pkg::WINDOW_DEPTH)
        begin
            cfg_eff.win = srrw_pkg::WIN_W'(srrw_pkg::WINDOW_DEPTH);
        end

        cfg_eff.chunk = chunk_size_reg;
        if (chunk_size_reg == '0)
        begin
            cfg_eff.chunk = srrw_pkg::CHUNK_W'(1);
        end
        else if (int'(chunk_size_reg) > srrw_pkg::CHUNK_MAX)
        begin
            cfg_eff.chunk = srrw_pkg::CHUNK_W'(srrw_pkg::CHUNK_MAX);
        end
    end

    // Front: classify and queue each header transaction
    srrw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pkt_type    (pkt_type),
        .seq_num     (seq_num),
        .checksum_ok (checksum_ok),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry)
    );

    // Back: session/window update, offset multiply, result register
    srrw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign ack_send     = result.ack_send;
    assign ack_seq      = result.ack_seq;
    assign write_chunk  = result.write_chunk;
    assign write_offset = result.write_offset;
    assign session_done = result.session_done;
    assign status       = result.status;

endmodule
